// ----- design/tsjf_pkg.sv -----
// Shared types, constants and the control program of the touch sample jitter filter.
// Used by the sequencer and the top module of the block; depends on nothing.
package tsjf_pkg;

  localparam int COORD_W          = 10;
  localparam int PRESS_W          = 16;
  localparam int MIN_W            = 4;
  localparam int SQ_W             = 2 * COORD_W;
  localparam int SAMPLE_DEPTH_DFLT = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT         = 2'd2;

  localparam logic [PRESS_W-1:0] THRESHOLD_RST = 16'd1;
  localparam logic [MIN_W-1:0]   MIN_RST       = 4'd3;
  localparam logic [SQ_W-1:0]    LIMIT_SQ_RST  = 20'd256;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    logic [COORD_W-1:0] x_raw;
    logic [COORD_W-1:0] y_raw;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic               pen_down;
  } out_item_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_STORE,
    OP_CLEAR_ACC,
    OP_IDX_INC,
    OP_LOAD_PREV,
    OP_SQUARE,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SET_DOWN,
    OP_SET_UP,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_PEN_UP,
    C_NOT_CLOSE,
    C_WALK_DONE,
    C_NO_KEPT,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] ST_CLASSIFY = 4'd1;
  localparam logic [PC_W-1:0] ST_STORE    = 4'd2;
  localparam logic [PC_W-1:0] ST_CHECK    = 4'd3;
  localparam logic [PC_W-1:0] ST_RD0      = 4'd4;
  localparam logic [PC_W-1:0] ST_PREV     = 4'd5;
  localparam logic [PC_W-1:0] ST_DIST     = 4'd6;
  localparam logic [PC_W-1:0] ST_ACC      = 4'd7;
  localparam logic [PC_W-1:0] ST_DIVINIT  = 4'd8;
  localparam logic [PC_W-1:0] ST_DIVSTEP  = 4'd9;
  localparam logic [PC_W-1:0] ST_DIVDONE  = 4'd10;
  localparam logic [PC_W-1:0] ST_PENUP    = 4'd11;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd12;
  localparam logic [PC_W-1:0] ST_DONE     = 4'd13;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Status flags that the datapath hands to the sequencer.
  typedef struct packed {
    logic no_item;
    logic pen_up;
    logic not_close;
    logic walk_done;
    logic no_kept;
    logic div_more;
    logic out_busy;
  } cond_flags_t;

  // The control program. A step whose condition holds jumps to its target,
  // otherwise the next step follows.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      ST_WAIT:     w = '{OP_LATCH,     C_NO_ITEM,   ST_WAIT};
      ST_CLASSIFY: w = '{OP_NONE,      C_PEN_UP,    ST_PENUP};
      ST_STORE:    w = '{OP_STORE,     C_NEVER,     ST_WAIT};
      ST_CHECK:    w = '{OP_CLEAR_ACC, C_NOT_CLOSE, ST_WAIT};
      ST_RD0:      w = '{OP_IDX_INC,   C_NEVER,     ST_WAIT};
      ST_PREV:     w = '{OP_LOAD_PREV, C_WALK_DONE, ST_DIVINIT};
      ST_DIST:     w = '{OP_SQUARE,    C_NEVER,     ST_WAIT};
      ST_ACC:      w = '{OP_ACCUM,     C_ALWAYS,    ST_PREV};
      ST_DIVINIT:  w = '{OP_DIV_INIT,  C_NO_KEPT,   ST_WAIT};
      ST_DIVSTEP:  w = '{OP_DIV_STEP,  C_DIV_MORE,  ST_DIVSTEP};
      ST_DIVDONE:  w = '{OP_SET_DOWN,  C_ALWAYS,    ST_EMIT};
      ST_PENUP:    w = '{OP_SET_UP,    C_NEVER,     ST_WAIT};
      ST_EMIT:     w = '{OP_EMIT,      C_OUT_BUSY,  ST_EMIT};
      ST_DONE:     w = '{OP_NONE,      C_ALWAYS,    ST_WAIT};
      default:     w = '{OP_NONE,      C_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- design/tsjf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module tsjf_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tsjf_seq.sv -----
// Step counter and control store of the jitter filter's sequencer.
// Depends on tsjf_pkg for the control word, conditions and program.
module tsjf_seq
  import tsjf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cond_flags_t flags,
  output ucode_t      ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ITEM:   take = flags.no_item;
      C_PEN_UP:    take = flags.pen_up;
      C_NOT_CLOSE: take = flags.not_close;
      C_WALK_DONE: take = flags.walk_done;
      C_NO_KEPT:   take = flags.no_kept;
      C_DIV_MORE:  take = flags.div_more;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- design/touch_sample_jitter_filter.sv -----
// Touch sample jitter filter: microcoded sequencer over a small datapath. Synchronous active-low
// reset restores the register defaults and empties the window.
// A pressed item that leaves the window open is only stored; a pen-up item emits the last position
// with pen_down low and empties the window. A closed window is averaged over its kept samples by a
// restoring divider on SUM_W = 10 + clog2(SAMPLE_DEPTH) bits; nothing is emitted if none is kept.
// The next item is only taken once the filter is done with the last one.
module touch_sample_jitter_filter
  import tsjf_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW     = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int KEPT_W = AW;
  localparam int SUM_W  = COORD_W + KEPT_W;
  localparam int BIT_W  = $clog2(SUM_W + 1);
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  ucode_t      ctrl;
  cond_flags_t flags;

  // Configuration.
  logic [PRESS_W-1:0] thr_r;
  logic [MIN_W-1:0]   min_r;
  logic [SQ_W-1:0]    limit_sq_r;
  logic [COORD_W-1:0] cfg_limit;

  // Datapath state.
  logic [COORD_W-1:0] x_r, y_r, prev_x_r, prev_y_r, last_x_r, last_y_r;
  logic               pen_up_r;
  logic [CNT_W-1:0]   count_r, count_nxt, idx_r, idx_nxt;
  logic [KEPT_W-1:0]  kept_r, kept_nxt;
  logic [SUM_W-1:0]   sum_x_r, sum_y_r;
  logic [SQ_W-1:0]    dsq_x_r, dsq_y_r;
  logic [KEPT_W-1:0]  rem_x_r, rem_y_r;
  logic [SUM_W-1:0]   quo_x_r, quo_y_r;
  logic [BIT_W-1:0]   bit_cnt_r;
  logic [COORD_W-1:0] last_x_nxt, last_y_nxt;
  out_item_t          res_r;
  out_item_t          out_data_r;
  logic               out_valid_r, out_valid_nxt;

  // Sample RAM.
  logic                 ram_we;
  logic [2*COORD_W-1:0] ram_rdata;
  logic [COORD_W-1:0]   rd_x, rd_y;

  // Arithmetic.
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W:0]      dist_sq;
  logic               keep;
  logic [KEPT_W:0]    trial_x, trial_y, diff_x, diff_y;
  logic               ge_x, ge_y;
  logic               accept_in, out_busy;

  tsjf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  tsjf_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({x_r, y_r}),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[2*COORD_W-1:COORD_W];
  assign rd_y = ram_rdata[COORD_W-1:0];

  assign in_stall  = (ctrl.op != OP_LATCH);
  assign accept_in = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ram_we    = (ctrl.op == OP_STORE);
  assign cfg_limit = cfg_wdata[COORD_W-1:0];

  always_comb begin
    flags.no_item   = !in_valid;
    flags.pen_up    = pen_up_r;
    flags.not_close = (CMP_W'(count_r) <= CMP_W'(min_r)) &&
                      (count_r < CNT_W'(SAMPLE_DEPTH));
    flags.walk_done = (idx_r >= count_r);
    flags.no_kept   = (kept_r == '0);
    flags.div_more  = (bit_cnt_r != BIT_W'(1));
    flags.out_busy  = out_busy;
  end

  assign dx      = (rd_x >= prev_x_r) ? (rd_x - prev_x_r) : (prev_x_r - rd_x);
  assign dy      = (rd_y >= prev_y_r) ? (rd_y - prev_y_r) : (prev_y_r - rd_y);
  assign dist_sq = {1'b0, dsq_x_r} + {1'b0, dsq_y_r};
  assign keep    = (dist_sq < {1'b0, limit_sq_r});

  // One restoring division step per cycle for both coordinates.
  assign trial_x = {rem_x_r, quo_x_r[SUM_W-1]};
  assign trial_y = {rem_y_r, quo_y_r[SUM_W-1]};
  assign diff_x  = trial_x - {1'b0, kept_r};
  assign diff_y  = trial_y - {1'b0, kept_r};
  assign ge_x    = (trial_x >= {1'b0, kept_r});
  assign ge_y    = (trial_y >= {1'b0, kept_r});

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (ctrl.op)
      OP_STORE:     count_nxt = count_r + CNT_W'(1);
      OP_CLEAR_ACC: begin
        idx_nxt  = '0;
        kept_nxt = '0;
      end
      OP_IDX_INC:   idx_nxt = idx_r + CNT_W'(1);
      OP_ACCUM: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (keep) begin
          kept_nxt = kept_r + KEPT_W'(1);
        end
      end
      OP_DIV_INIT:  count_nxt = '0;
      OP_SET_DOWN: begin
        last_x_nxt = quo_x_r[COORD_W-1:0];
        last_y_nxt = quo_y_r[COORD_W-1:0];
      end
      OP_SET_UP:    count_nxt = '0;
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      min_r       <= MIN_RST;
      limit_sq_r  <= LIMIT_SQ_RST;
      count_r     <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PRESSURE_THRESHOLD: thr_r      <= cfg_wdata[PRESS_W-1:0];
          CFG_MIN_SAMPLES:        min_r      <= cfg_wdata[MIN_W-1:0];
          CFG_MOVE_LIMIT:         limit_sq_r <= cfg_limit * cfg_limit;
          default: begin
          end
        endcase
      end
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      kept_r      <= kept_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        if (accept_in) begin
          x_r      <= in_data.x_raw;
          y_r      <= in_data.y_raw;
          pen_up_r <= (in_data.pressure < thr_r);
        end
      end
      OP_CLEAR_ACC: begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end
      OP_LOAD_PREV: begin
        prev_x_r <= rd_x;
        prev_y_r <= rd_y;
      end
      OP_SQUARE: begin
        dsq_x_r <= dx * dx;
        dsq_y_r <= dy * dy;
      end
      OP_ACCUM: begin
        if (keep) begin
          sum_x_r <= sum_x_r + SUM_W'(rd_x);
          sum_y_r <= sum_y_r + SUM_W'(rd_y);
        end
      end
      OP_DIV_INIT: begin
        rem_x_r   <= '0;
        rem_y_r   <= '0;
        quo_x_r   <= sum_x_r;
        quo_y_r   <= sum_y_r;
        bit_cnt_r <= BIT_W'(SUM_W);
      end
      OP_DIV_STEP: begin
        rem_x_r   <= ge_x ? diff_x[KEPT_W-1:0] : trial_x[KEPT_W-1:0];
        rem_y_r   <= ge_y ? diff_y[KEPT_W-1:0] : trial_y[KEPT_W-1:0];
        quo_x_r   <= {quo_x_r[SUM_W-2:0], ge_x};
        quo_y_r   <= {quo_y_r[SUM_W-2:0], ge_y};
        bit_cnt_r <= bit_cnt_r - BIT_W'(1);
      end
      OP_SET_DOWN: res_r <= '{quo_x_r[COORD_W-1:0], quo_y_r[COORD_W-1:0], 1'b1};
      OP_SET_UP:   res_r <= '{last_x_r, last_y_r, 1'b0};
      OP_EMIT: begin
        if (!out_busy) begin
          out_data_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // A new result only appears after the emit step of the program.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");

  // The window never holds more samples than the RAM has entries.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SAMPLE_DEPTH))
    else $error("sample count beyond window depth");

  // A sample is only written while the window still has room.
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_STORE) |-> (count_r < CNT_W'(SAMPLE_DEPTH)))
    else $error("sample written into a full window");

  // Kept samples can never outnumber the pairs walked so far.
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(kept_r) <= idx_r) || (ctrl.op == OP_NONE && idx_r == '0))
    else $error("kept count exceeds walked pairs");

endmodule
